/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, which are empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/sqcp_pkg.sv */
// ---------------------------------------------------------------------------
// sqcp_pkg
// Shared constants, a saturation helper and a sign-extension helper for the sphere/quad push-out block.
// ---------------------------------------------------------------------------
package sqcp_pkg;
   localparam int WORD_W         = 32;
   localparam int WORDS_PER_SURF = 15;
   localparam int COUNT_W        = 7;
   localparam int RAD_W          = 31;
   localparam int ACC_W          = 64;

   // Request kinds carried on tuser
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Clamp an exact value to the signed 32-bit range
   function automatic logic signed [WORD_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = 64'sd2147483647;
      lo = -64'sd2147483648;
      if (x > hi) begin
         sat32 = 32'sh7fffffff;
      end else if (x < lo) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = x[WORD_W-1:0];
      end
   endfunction

   // Sign-extend one word to accumulator width
   function automatic logic signed [ACC_W-1:0] sx64(input logic signed [WORD_W-1:0] a);
      sx64 = ACC_W'(a);
   endfunction
endpackage

/* rtl/sqcp_surface_ram.sv */
// ---------------------------------------------------------------------------
// sqcp_surface_ram
// Surface store: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module sqcp_surface_ram #(
   parameter int DEPTH = 960
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [$clog2(DEPTH)-1:0]            wr_addr,
   input  logic signed [sqcp_pkg::WORD_W-1:0]  wr_data,
   input  logic                                rd_en,
   input  logic [$clog2(DEPTH)-1:0]            rd_addr,
   output logic signed [sqcp_pkg::WORD_W-1:0]  rd_data
);
   logic signed [sqcp_pkg::WORD_W-1:0] mem [DEPTH];
   logic signed [sqcp_pkg::WORD_W-1:0] rd_data_ff;

   // Write a word; read data is registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/sphere_quad_collision_pushout.sv */
// Load word: accepted, no result.
// Query word: for each surface that reaches every edge test, the block streams its 15 words,
//   runs the subtract, distance, edge and advance steps, and forms each of the 45 products
//   in turn on the shared multiplier.
// Result is held in an output register; a new word is taken once the result has moved there.
// Synchronous active-high reset clears control, count and output valid; the store is not cleared.
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// sphere_quad_collision_pushout
// Walks stored quad surfaces and pushes a sphere center out of each one hit.
// ---------------------------------------------------------------------------
module sphere_quad_collision_pushout #(
   parameter int MAX_SURFACES = 64,
   parameter int FRAC_BITS    = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // surface_index[5:0] coord_index[9:6] coord_value[41:10] center_x[73:42]
   // center_y[105:74] center_z[137:106] sphere_radius[168:138], zero above
   input  logic [175:0] req_tdata,
   // cmd[0]
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_x[31:0] out_y[63:32] out_z[95:64]
   output logic [95:0]  rsp_tdata,
   // collided[0]
   output logic         rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [6:0]   csr_data
);
   localparam int DEPTH = MAX_SURFACES * sqcp_pkg::WORDS_PER_SURF;
   localparam int AW    = $clog2(DEPTH);
   localparam int SW    = $clog2(MAX_SURFACES + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_READ  = 4'd1;
   localparam logic [3:0] S_DIFF  = 4'd2;
   localparam logic [3:0] S_DOT   = 4'd3;
   localparam logic [3:0] S_DIST  = 4'd4;
   localparam logic [3:0] S_PROJ  = 4'd5;
   localparam logic [3:0] S_EDGE  = 4'd6;
   localparam logic [3:0] S_CROSS = 4'd7;
   localparam logic [3:0] S_EDOT  = 4'd8;
   localparam logic [3:0] S_PUSH  = 4'd9;
   localparam logic [3:0] S_NEXT  = 4'd10;
   localparam logic [3:0] S_DONE  = 4'd11;

   typedef logic signed [sqcp_pkg::WORD_W-1:0] word_type;

   logic [3:0]      state_ff;
   logic [4:0]      cnt_ff;
   logic [2:0]      k_ff;
   logic            mph_ff;
   logic [1:0]      e_ff;
   logic [SW-1:0]   i_ff;
   logic [SW-1:0]   n_ff;
   logic [AW-1:0]   base_ff;
   logic [6:0]      count_ff;
   logic [30:0]     rad_ff;
   logic [30:0]     dist_ff;
   logic            hit_ff;
   word_type        cen_ff  [3];
   word_type        surf_ff [15];
   word_type        vec_ff  [3];
   word_type        w_ff    [3];
   word_type        r_ff    [3];
   word_type        ps_ff   [3];
   logic signed [63:0] acc_ff;
   logic signed [63:0] prod_ff;
   logic            rsp_valid_ff;
   logic [95:0]     rsp_data_ff;
   logic            rsp_user_ff;

   // Unpack the request word
   logic [5:0]  req_si;
   logic [3:0]  req_ci;
   word_type    req_cv;
   word_type    req_cx;
   word_type    req_cy;
   word_type    req_cz;
   logic [30:0] req_rad;
   assign req_si  = req_tdata[5:0];
   assign req_ci  = req_tdata[9:6];
   assign req_cv  = req_tdata[41:10];
   assign req_cx  = req_tdata[73:42];
   assign req_cy  = req_tdata[105:74];
   assign req_cz  = req_tdata[137:106];
   assign req_rad = req_tdata[168:138];

   logic req_acc;
   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Surface store
   logic     wr_en;
   logic     rd_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   word_type rd_data;
   assign wr_en   = req_acc && (req_tuser == sqcp_pkg::CMD_LOAD)
                    && (32'(req_si) < MAX_SURFACES)
                    && (req_ci < 4'(sqcp_pkg::WORDS_PER_SURF));
   assign wr_addr = AW'((32'(req_si) << 4) - 32'(req_si) + 32'(req_ci));
   assign rd_en   = (state_ff == S_READ) && (cnt_ff < 5'(sqcp_pkg::WORDS_PER_SURF));
   assign rd_addr = base_ff + AW'(cnt_ff);

   sqcp_surface_ram #(.DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_cv),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Derived scalars
   logic signed [63:0] mq;
   logic signed [63:0] abs_acc;
   logic [30:0]        dist_c;
   word_type           neg_dist;
   word_type           rmd;
   logic signed [63:0] edot_sum;
   logic [SW-1:0]      n_c;
   logic [3:0]         nrm_idx;
   logic               mul_step;
   assign mq       = prod_ff >>> FRAC_BITS;
   assign abs_acc  = (acc_ff < 0) ? -acc_ff : acc_ff;
   assign dist_c   = (abs_acc > 64'sd2147483647) ? 31'h7fffffff : abs_acc[30:0];
   assign neg_dist = -$signed({1'b0, dist_ff});
   assign rmd      = $signed({1'b0, rad_ff}) - $signed({1'b0, dist_ff});
   assign edot_sum = acc_ff + mq;
   assign n_c      = (32'(count_ff) > MAX_SURFACES) ? SW'(MAX_SURFACES) : SW'(count_ff);
   assign nrm_idx  = 4'd12 + {2'b00, k_ff[1:0]};
   assign mul_step = (state_ff == S_DOT) || (state_ff == S_PROJ) || (state_ff == S_CROSS)
                     || (state_ff == S_EDOT) || (state_ff == S_PUSH);

   // Select multiplier operands
   word_type opa;
   word_type opb;
   always_comb begin
      opa = vec_ff[0];
      opb = surf_ff[12];
      case (state_ff)
         S_DOT: begin
            opa = vec_ff[k_ff[1:0]];
            opb = surf_ff[nrm_idx];
         end
         S_PROJ: begin
            opa = surf_ff[nrm_idx];
            opb = neg_dist;
         end
         S_CROSS: begin
            case (k_ff)
               3'd0:    begin opa = vec_ff[1]; opb = surf_ff[14]; end
               3'd1:    begin opa = vec_ff[2]; opb = surf_ff[13]; end
               3'd2:    begin opa = vec_ff[2]; opb = surf_ff[12]; end
               3'd3:    begin opa = vec_ff[0]; opb = surf_ff[14]; end
               3'd4:    begin opa = vec_ff[0]; opb = surf_ff[13]; end
               default: begin opa = vec_ff[1]; opb = surf_ff[12]; end
            endcase
         end
         S_EDOT: begin
            opa = r_ff[k_ff[1:0]];
            opb = w_ff[k_ff[1:0]];
         end
         S_PUSH: begin
            opa = surf_ff[nrm_idx];
            opb = rmd;
         end
         default: begin
            opa = vec_ff[0];
            opb = surf_ff[12];
         end
      endcase
   end

   // Product register of the shared multiplier
   always_ff @(posedge clock) begin
      if (!mph_ff) begin
         prod_ff <= opa * opb;
      end
   end

   // Count register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         count_ff <= csr_data;
      end
   end

   // Sequencer: stream a surface, then step the arithmetic through the multiplier
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         k_ff         <= '0;
         mph_ff       <= 1'b0;
         e_ff         <= '0;
         i_ff         <= '0;
         n_ff         <= '0;
         base_ff      <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Drop the result once taken, unless a new one replaces it this cycle
         if (rsp_valid_ff && rsp_tready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_acc && (req_tuser == sqcp_pkg::CMD_QUERY)) begin
                  cen_ff[0] <= req_cx;
                  cen_ff[1] <= req_cy;
                  cen_ff[2] <= req_cz;
                  rad_ff    <= req_rad;
                  hit_ff    <= 1'b0;
                  i_ff      <= '0;
                  base_ff   <= '0;
                  cnt_ff    <= '0;
                  n_ff      <= n_c;
                  state_ff  <= (n_c == '0) ? S_DONE : S_READ;
               end
            end
            S_READ: begin
               if (cnt_ff != 5'd0) begin
                  surf_ff[cnt_ff[3:0] - 4'd1] <= rd_data;
               end
               if (cnt_ff == 5'(sqcp_pkg::WORDS_PER_SURF)) begin
                  state_ff <= S_DIFF;
               end
               cnt_ff <= cnt_ff + 5'd1;
            end
            S_DIFF: begin
               for (int j = 0; j < 3; j++) begin
                  vec_ff[j] <= sqcp_pkg::sat32(sqcp_pkg::sx64(cen_ff[j])
                                               - sqcp_pkg::sx64(surf_ff[j]));
               end
               k_ff     <= '0;
               mph_ff   <= 1'b0;
               state_ff <= S_DOT;
            end
            S_DOT: begin
               mph_ff <= !mph_ff;
               if (mph_ff) begin
                  acc_ff <= ((k_ff == 3'd0) ? 64'sd0 : acc_ff) + mq;
                  if (k_ff == 3'd2) begin
                     k_ff     <= '0;
                     state_ff <= S_DIST;
                  end else begin
                     k_ff <= k_ff + 3'd1;
                  end
               end
            end
            S_DIST: begin
               dist_ff  <= dist_c;
               state_ff <= (dist_c >= rad_ff) ? S_NEXT : S_PROJ;
            end
            S_PROJ: begin
               mph_ff <= !mph_ff;
               if (mph_ff) begin
                  ps_ff[k_ff[1:0]] <= sqcp_pkg::sat32(sqcp_pkg::sx64(cen_ff[k_ff[1:0]]) + mq);
                  if (k_ff == 3'd2) begin
                     k_ff     <= '0;
                     e_ff     <= '0;
                     state_ff <= S_EDGE;
                  end else begin
                     k_ff <= k_ff + 3'd1;
                  end
               end
            end
            S_EDGE: begin
               // Edge vector and point offset from the leading vertex
               for (int j = 0; j < 3; j++) begin
                  vec_ff[j] <= sqcp_pkg::sat32(sqcp_pkg::sx64(surf_ff[3 + j])
                                               - sqcp_pkg::sx64(surf_ff[j]));
                  w_ff[j]   <= sqcp_pkg::sat32(sqcp_pkg::sx64(ps_ff[j])
                                               - sqcp_pkg::sx64(surf_ff[j]));
               end
               k_ff     <= '0;
               state_ff <= S_CROSS;
            end
            S_CROSS: begin
               mph_ff <= !mph_ff;
               if (mph_ff) begin
                  if (!k_ff[0]) begin
                     acc_ff <= mq;
                  end else begin
                     r_ff[k_ff[2:1]] <= sqcp_pkg::sat32(acc_ff - mq);
                  end
                  if (k_ff == 3'd5) begin
                     k_ff     <= '0;
                     state_ff <= S_EDOT;
                  end else begin
                     k_ff <= k_ff + 3'd1;
                  end
               end
            end
            S_EDOT: begin
               mph_ff <= !mph_ff;
               if (mph_ff) begin
                  acc_ff <= ((k_ff == 3'd0) ? 64'sd0 : acc_ff) + mq;
                  if (k_ff == 3'd2) begin
                     k_ff <= '0;
                     if (edot_sum > 0) begin
                        state_ff <= S_NEXT;
                     end else begin
                        // Rotate vertices so the next edge starts at slot zero
                        for (int j = 0; j < 12; j++) begin
                           surf_ff[j] <= surf_ff[(j + 3) % 12];
                        end
                        e_ff     <= e_ff + 2'd1;
                        state_ff <= (e_ff == 2'd3) ? S_PUSH : S_EDGE;
                     end
                  end else begin
                     k_ff <= k_ff + 3'd1;
                  end
               end
            end
            S_PUSH: begin
               mph_ff <= !mph_ff;
               if (mph_ff) begin
                  cen_ff[k_ff[1:0]] <= sqcp_pkg::sat32(sqcp_pkg::sx64(cen_ff[k_ff[1:0]]) + mq);
                  if (k_ff == 3'd2) begin
                     k_ff     <= '0;
                     hit_ff   <= 1'b1;
                     state_ff <= S_NEXT;
                  end else begin
                     k_ff <= k_ff + 3'd1;
                  end
               end
            end
            S_NEXT: begin
               i_ff    <= i_ff + SW'(1);
               base_ff <= base_ff + AW'(sqcp_pkg::WORDS_PER_SURF);
               cnt_ff  <= '0;
               state_ff <= (i_ff + SW'(1) == n_ff) ? S_DONE : S_READ;
            end
            S_DONE: begin
               // Hand the result to the output register once it is free
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {cen_ff[2], cen_ff[1], cen_ff[0]};
                  rsp_user_ff  <= hit_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `ASSERT_RST(a_mph_state, clock, reset, mph_ff |-> mul_step, "multiplier phase outside a multiply step")
   `ASSERT_RST(a_read_range, clock, reset, (state_ff == S_READ) |-> (i_ff < n_ff),
               "surface index past count")
   `ASSERT_RST(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE),
               "result raised outside done step")
   `ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> (state_ff == S_IDLE && !rsp_valid_ff),
                  "not idle after reset")
endmodule

/* verif/tb_sphere_quad_collision_pushout.sv */
// ----------------------------------------------------------------------------
// tb_sphere_quad_collision_pushout
// Streams surface loads and sphere queries into the push-out block. A
// scoreboard works out each final center and collided flag and compares
// them with the response words in order, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_sphere_quad_collision_pushout;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_SLOTS = 64;
   localparam int FRAC      = 16;
   localparam int COORD_NRM = 12;
   localparam int COORD_BAD = 15;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic        hit;
   } center_type;

   // Scoreboard: own copy of the surface store, count and pending centers
   class pushout_scoreboard;
      logic signed [sqcp_pkg::WORD_W-1:0] surf_mem [NUM_SLOTS*sqcp_pkg::WORDS_PER_SURF];
      logic [sqcp_pkg::COUNT_W-1:0]       surf_count;
      center_type               centers_due [$];
      int                       mismatches;
      int                       queries;
      int                       hits;

      function new();
         foreach (surf_mem[i]) surf_mem[i] = '0;
         surf_count = '0;
         mismatches = 0;
         queries    = 0;
         hits       = 0;
      endfunction

      function longint clamp32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      // Fixed-point product, floor toward minus infinity
      function longint qmul(longint a, longint b);
         longint p;
         p = a * b;
         return p >>> FRAC;
      endfunction

      function void set_count(logic [sqcp_pkg::COUNT_W-1:0] n);
         surf_count = n;
      endfunction

      function void note_item(bit cmd, logic [5:0] si, logic [3:0] ci, logic [31:0] cv,
                              logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                              logic [30:0] rad);
         longint c[3], vx[4][3], nrm[3], d[3], ps[3], u[3], r[3], v[3];
         longint pdist, radius, acc;
         int n, e, k, e1, base;
         bit in_quad, any_hit;
         center_type res;
         if (cmd == sqcp_pkg::CMD_LOAD) begin
            if (si < NUM_SLOTS && ci != COORD_BAD)
               surf_mem[si*sqcp_pkg::WORDS_PER_SURF + ci] = cv;
            return;
         end
         c[0] = longint'($signed(cx));
         c[1] = longint'($signed(cy));
         c[2] = longint'($signed(cz));
         radius = longint'(rad);
         n = (surf_count > NUM_SLOTS) ? NUM_SLOTS : surf_count;
         any_hit = 1'b0;
         for (int i = 0; i < n; i++) begin
            base = i * sqcp_pkg::WORDS_PER_SURF;
            for (e = 0; e < 4; e++)
               for (k = 0; k < 3; k++) vx[e][k] = surf_mem[base + e*3 + k];
            for (k = 0; k < 3; k++) nrm[k] = surf_mem[base + COORD_NRM + k];
            for (k = 0; k < 3; k++) d[k] = clamp32(c[k] - vx[0][k]);
            pdist = qmul(d[0], nrm[0]) + qmul(d[1], nrm[1]) + qmul(d[2], nrm[2]);
            if (pdist < 0) pdist = -pdist;
            pdist = clamp32(pdist);
            if (pdist >= radius) continue;
            // project along the negative normal, then test the edge half-planes
            for (k = 0; k < 3; k++) ps[k] = clamp32(c[k] + qmul(nrm[k], -pdist));
            in_quad = 1'b1;
            for (e = 0; e < 4 && in_quad; e++) begin
               e1 = (e + 1) & 3;
               for (k = 0; k < 3; k++) u[k] = clamp32(vx[e1][k] - vx[e][k]);
               r[0] = clamp32(qmul(u[1], nrm[2]) - qmul(u[2], nrm[1]));
               r[1] = clamp32(qmul(u[2], nrm[0]) - qmul(u[0], nrm[2]));
               r[2] = clamp32(qmul(u[0], nrm[1]) - qmul(u[1], nrm[0]));
               for (k = 0; k < 3; k++) v[k] = clamp32(ps[k] - vx[e][k]);
               acc = qmul(r[0], v[0]) + qmul(r[1], v[1]) + qmul(r[2], v[2]);
               if (acc > 0) in_quad = 1'b0;
            end
            if (!in_quad) continue;
            for (k = 0; k < 3; k++) c[k] = clamp32(c[k] + qmul(nrm[k], radius - pdist));
            any_hit = 1'b1;
         end
         res.x   = c[0][31:0];
         res.y   = c[1][31:0];
         res.z   = c[2][31:0];
         res.hit = any_hit;
         centers_due.push_back(res);
         queries++;
         if (any_hit) hits++;
      endfunction

      function void check_result(logic [95:0] data, logic user);
         center_type want;
         if (centers_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: response word %h/%b with nothing pending", data, user);
            return;
         end
         want = centers_due.pop_front();
         if (data[31:0] !== want.x || data[63:32] !== want.y ||
             data[95:64] !== want.z || user !== want.hit) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: center exp %h %h %h hit %b, got %h %h %h hit %b",
                        want.x, want.y, want.z, want.hit,
                        data[31:0], data[63:32], data[95:64], user);
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [175:0] req_tdata;
   logic         req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [95:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         csr_valid;
   logic         csr_ready;
   logic [6:0]   csr_data;

   pushout_scoreboard sb = new();
   int  send_idle_pct;
   int  rsp_stall_pct;
   bit  rsp_hold;
   int  items_sent;

   sphere_quad_collision_pushout #(.MAX_SURFACES(NUM_SLOTS), .FRAC_BITS(FRAC)) u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Drive response backpressure each cycle
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Check every accepted response word
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
   end

   // Offer one word, idling first at random, and hold until accepted
   task automatic send_word(bit cmd, logic [5:0] si, logic [3:0] ci, logic [31:0] cv,
                            logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                            logic [30:0] rad);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {7'd0, rad, cz, cy, cx, cv, ci, si};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_item(cmd, si, ci, cv, cx, cy, cz, rad);
      items_sent++;
   endtask

   task automatic load_word(logic [5:0] si, logic [3:0] ci, logic [31:0] cv);
      send_word(sqcp_pkg::CMD_LOAD, si, ci, cv, $urandom, $urandom, $urandom,
                31'($urandom));
   endtask

   task automatic query(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                        logic [30:0] rad);
      send_word(sqcp_pkg::CMD_QUERY, 6'($urandom), 4'($urandom), $urandom,
                cx, cy, cz, rad);
   endtask

   // Random Q16.16 value in [-span, span] units
   function automatic logic [31:0] rnd_q(int span);
      return $urandom_range(0, 2 * span * 65536) - span * 65536;
   endfunction

   // Load an axis-aligned rectangle with a unit normal; winding picked at random
   task automatic load_surface(logic [5:0] slot);
      logic [31:0] w[15];
      int ax, ua, wa;
      logic [31:0] off, u0, u1, w0, w1, uu[4], ww[4];
      ax = $urandom_range(2);
      ua = (ax + 1) % 3;
      wa = (ax + 2) % 3;
      off = rnd_q(4);
      u0 = rnd_q(4) - 32'sd262144;
      u1 = u0 + $urandom_range(65536, 6 * 65536);
      w0 = rnd_q(4) - 32'sd262144;
      w1 = w0 + $urandom_range(65536, 6 * 65536);
      uu = '{u0, u1, u1, u0};
      ww = '{w0, w0, w1, w1};
      if ($urandom_range(1)) begin
         uu = '{u0, u0, u1, u1};
         ww = '{w0, w1, w1, w0};
      end
      for (int e = 0; e < 4; e++) begin
         w[e*3 + ax] = off;
         w[e*3 + ua] = uu[e];
         w[e*3 + wa] = ww[e];
      end
      for (int k = 0; k < 3; k++) w[COORD_NRM + k] = '0;
      w[COORD_NRM + ax] = $urandom_range(1) ? 32'sd65536 : -32'sd65536;
      // now and then a surface of raw noise
      if ($urandom_range(9) == 0) foreach (w[i]) w[i] = $urandom;
      for (int i = 0; i < 15; i++) load_word(slot, i[3:0], w[i]);
   endtask

   // Pause the sender until every response is in, then let a load finish
   task automatic drain();
      int guard;
      req_tvalid <= 1'b0;
      guard = 0;
      while (sb.centers_due.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
   endtask

   task automatic write_count(logic [6:0] n);
      csr_valid <= 1'b1;
      csr_data  <= n;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_count(n);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_item();
      int pick;
      pick = $urandom_range(99);
      if (pick < 8) begin
         load_surface(6'($urandom_range(7)));
      end else if (pick < 14) begin
         // stray loads: any slot, sometimes the ignored coordinate, raw data
         load_word(6'($urandom),
                   ($urandom_range(3) == 0) ? 4'(COORD_BAD) : 4'($urandom_range(14)),
                   $urandom);
      end else if (pick < 20) begin
         query($urandom, $urandom, $urandom, 31'($urandom));
      end else begin
         query(rnd_q(8), rnd_q(8), rnd_q(8), 31'($urandom_range(0, 5 * 65536)));
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = 1'b0;
      csr_valid     = 1'b0;
      csr_data      = '0;
      rsp_hold      = 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      items_sent    = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: count zero, then extremes against eight loaded surfaces
      write_count(7'd0);
      query(32'h7fffffff, 32'h80000000, 32'h0, 31'h7fffffff);
      for (int s = 0; s < 8; s++) load_surface(s[5:0]);
      load_word(6'd63, 4'(COORD_BAD), 32'hffffffff);
      load_word(6'd63, 4'd14, 32'h80000000);
      drain();
      write_count(7'd8);
      query(32'h0, 32'h0, 32'h0, 31'd0);
      query(32'h0, 32'h0, 32'h0, 31'h7fffffff);
      query(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff);
      query(32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff);
      query(32'h00010000, 32'hffff0000, 32'h00008000, 31'h00030000);
      for (int i = 0; i < 6; i++) query(rnd_q(3), rnd_q(3), rnd_q(3), 31'h00040000);
      drain();

      // Random phases under different idling mixes
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 77; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 77; end
            default: begin send_idle_pct = 18; rsp_stall_pct = 18; end
         endcase
         write_count((ph == 0) ? 7'd8 : 7'($urandom_range(8)));
         if (ph == 0) begin
            // hold off the receiver long enough that the block backs up
            fork
               begin
                  rsp_hold = 1'b1;
                  repeat (4000) @(posedge clock);
                  rsp_hold = 1'b0;
               end
            join_none
         end
         for (int i = 0; i < 60; i++) random_item();
         drain();
      end

      // Fill more slots, then walk the longer store
      send_idle_pct = 0;
      rsp_stall_pct = 30;
      for (int s = 8; s < 24; s++) load_surface(s[5:0]);
      drain();
      write_count(7'd24);
      for (int i = 0; i < 3; i++) random_item();
      drain();
      for (int i = 0; i < 3; i++) query(rnd_q(6), rnd_q(6), rnd_q(6), 31'h00050000);
      drain();
      write_count(7'd1);
      for (int i = 0; i < 10; i++) random_item();
      drain();
      repeat (200) @(posedge clock);

      if (sb.centers_due.size() != 0) sb.mismatches += sb.centers_due.size();
      $display("Sent %0d words, %0d queries of which %0d pushed the center out.",
               items_sent, sb.queries, sb.hits);
      $display("Surface counts 0 to 24 walked with stray loads mixed in; %0d mismatches.",
               sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #100ms;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
